@@ src/vkmt_pkg.sv @@
// Package for the velocity key matrix tracker.
// Holds phase and FSM types, register indexes, defaults and the pitch table.
// Used by vkmt_key_store and velocity_key_matrix_tracker_top.
package vkmt_pkg;

  localparam int unsigned NUM_ROWS        = 12;
  localparam int unsigned DEF_NUM_COLUMNS = 8;
  localparam int unsigned DEF_TIME_WIDTH  = 32;
  localparam int unsigned SEMITONES       = 12;

  localparam logic [15:0] VEL_DIVISOR_RST  = 16'd100;
  localparam logic [6:0]  MAX_VELOCITY_RST = 7'd127;
  localparam logic [6:0]  NOTE_MAX         = 7'd127;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_VEL_DIVISOR  = 1'b0;
  localparam cfg_idx_t REG_MAX_VELOCITY = 1'b1;

  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FLOATING,
    PH_PRESSED,
    PH_RELEASED
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic   rd_en;
    logic   phase_we;
    logic   time_we;
    phase_e phase;
  } ks_ctrl_t;

  function automatic logic [6:0] pitch_base(input logic [3:0] row);
    logic [6:0] base;
    case (row)
      4'd0:    base = 7'd36;
      4'd1:    base = 7'd25;
      4'd2:    base = 7'd26;
      4'd3:    base = 7'd27;
      4'd4:    base = 7'd28;
      4'd5:    base = 7'd29;
      4'd6:    base = 7'd30;
      4'd7:    base = 7'd31;
      4'd8:    base = 7'd32;
      4'd9:    base = 7'd33;
      4'd10:   base = 7'd34;
      4'd11:   base = 7'd35;
      default: base = 7'd0;
    endcase
    return base;
  endfunction

endpackage

@@ src/vkmt_key_store.sv @@
// Per-key state store: phase memory with reset valid bits, float start time memory.
// Both memories read synchronously; read data is registered and valid in the cycle after rd_en. Depends on vkmt_pkg.
module vkmt_key_store #(
  parameter int unsigned DEPTH = 96,
  parameter int unsigned AW    = 7,
  parameter int unsigned TW    = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vkmt_pkg::ks_ctrl_t  ctrl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [TW-1:0]       wr_time_i,
  output vkmt_pkg::phase_e    rd_phase_o,
  output logic [TW-1:0]       rd_time_o
);
  import vkmt_pkg::*;

  phase_e        phase_mem [DEPTH];
  logic [TW-1:0] time_mem  [DEPTH];
  logic [DEPTH-1:0] valid_q;

  phase_e        phase_rd_q;
  logic          valid_rd_q;
  logic [TW-1:0] time_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.phase_we) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.phase_we) begin
      phase_mem[addr_i] <= ctrl_i.phase;
    end
    if (ctrl_i.time_we) begin
      time_mem[addr_i] <= wr_time_i;
    end
    if (ctrl_i.rd_en) begin
      phase_rd_q <= phase_mem[addr_i];
      valid_rd_q <= valid_q[addr_i];
      time_rd_q  <= time_mem[addr_i];
    end
  end

  assign rd_phase_o = valid_rd_q ? phase_rd_q : PH_IDLE;
  assign rd_time_o  = time_rd_q;

endmodule

@@ src/vkmt_vel_div.sv @@
// Serial restoring divider: TW-bit elapsed time by 16-bit divisor, one bit per cycle.
// A zero divisor is taken as one. Standalone, no package use.
module vkmt_vel_div #(
  parameter int unsigned TW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [TW-1:0] dividend_i,
  input  logic [15:0]   divisor_i,
  output logic          done_o,
  output logic [TW-1:0] quotient_o
);
  localparam int unsigned CNT_W = $clog2(TW + 1);

  logic [TW-1:0]    dvd_q;
  logic [15:0]      rem_q;
  logic [15:0]      dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [16:0] shifted;
  logic [16:0] diff;
  logic        ge;

  assign shifted = {rem_q, dvd_q[TW-1]};
  assign diff    = shifted - {1'b0, dsr_q};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(TW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= (divisor_i == 16'd0) ? 16'd1 : divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TW-2:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

@@ src/velocity_key_matrix_tracker_top.sv @@
// Velocity key matrix tracker, top level: APB registers, control FSM, output register.
// Instantiates vkmt_key_store and vkmt_vel_div; depends on vkmt_pkg.
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_ready_o   | key_column_i, key_row_i, contact_closed_i, time_us_i
//   out     | out_valid_o / out_ready_i | event_kind_o, note_number_o, velocity_o
//   cfg     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// A sample passes the accept, memory read and update states; a note-off adds a push state;
// a note-on adds the bit-serial divider and then the push state. An out-of-range sample is
// dropped in its accept cycle.
// One sample is in work at a time; the next is taken once the previous result sits in
// the output register, which holds while out_ready_i is low.
// Reset marks every key idle through per-key valid bits; no clearing pass is needed.
module velocity_key_matrix_tracker_top #(
  parameter int unsigned NUM_COLUMNS = vkmt_pkg::DEF_NUM_COLUMNS,
  parameter int unsigned TIME_WIDTH  = vkmt_pkg::DEF_TIME_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  key_column_i,
  input  logic [3:0]  key_row_i,
  input  logic        contact_closed_i,
  input  logic [31:0] time_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        event_kind_o,
  output logic [6:0]  note_number_o,
  output logic [6:0]  velocity_o
);
  import vkmt_pkg::*;

  localparam int unsigned NUM_KEYS = NUM_COLUMNS * NUM_ROWS;
  localparam int unsigned KEY_AW   = $clog2(NUM_KEYS);
  localparam int unsigned TW       = TIME_WIDTH;

  // configuration registers
  logic [15:0] vel_div_q;
  logic [6:0]  max_vel_q;
  logic        cfg_we;
  cfg_idx_t    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_div_q <= VEL_DIVISOR_RST;
      max_vel_q <= MAX_VELOCITY_RST;
    end else if (cfg_we) begin
      if (cfg_idx == REG_VEL_DIVISOR) begin
        vel_div_q <= pwdata[15:0];
      end else begin
        max_vel_q <= pwdata[6:0];
      end
    end
  end

  assign prdata = (cfg_idx == REG_VEL_DIVISOR) ? {16'd0, vel_div_q} : {25'd0, max_vel_q};

  // sample capture
  state_e state_q, state_d;

  logic [2:0]    col_q;
  logic [3:0]    row_q;
  logic          closed_q;
  logic [TW-1:0] now_q;
  logic [63:0]   time_ext;
  logic          in_range;
  logic          accept;
  logic [7:0]    key_idx_full;
  logic [KEY_AW-1:0] key_idx;

  assign time_ext = {32'd0, time_us_i};
  assign in_range = (32'(key_column_i) < NUM_COLUMNS) && (32'(key_row_i) < NUM_ROWS);
  assign accept   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q    <= key_column_i;
      row_q    <= key_row_i;
      closed_q <= contact_closed_i;
      now_q    <= time_ext[TW-1:0];
    end
  end

  assign key_idx_full = 8'(col_q) * 8'(SEMITONES) + 8'(row_q);
  assign key_idx      = key_idx_full[KEY_AW-1:0];

  // key store and divider
  ks_ctrl_t      ks_ctrl;
  phase_e        rd_phase;
  logic [TW-1:0] rd_time;
  logic [TW-1:0] elapsed;
  logic          div_start;
  logic          div_done;
  logic [TW-1:0] quotient;

  vkmt_key_store #(
    .DEPTH (NUM_KEYS),
    .AW    (KEY_AW),
    .TW    (TW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ks_ctrl),
    .addr_i     (key_idx),
    .wr_time_i  (now_q),
    .rd_phase_o (rd_phase),
    .rd_time_o  (rd_time)
  );

  assign elapsed = now_q - rd_time;

  vkmt_vel_div #(
    .TW (TW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (vel_div_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // phase decode
  logic go_float, go_press, go_release, go_rest;

  assign go_float   = (rd_phase == PH_IDLE)     && !closed_q;
  assign go_press   = (rd_phase == PH_FLOATING) &&  closed_q;
  assign go_release = (rd_phase == PH_PRESSED)  && !closed_q;
  assign go_rest    = (rd_phase == PH_RELEASED) && !closed_q;

  // velocity from quotient
  logic       q_sat;
  logic [6:0] vel_calc;

  assign q_sat    = (|quotient[TW-1:7]) || (quotient[6:0] >= max_vel_q);
  assign vel_calc = q_sat ? 7'd1 : (max_vel_q - quotient[6:0]);

  // note number
  logic [7:0] note_sum;
  logic [6:0] note;

  assign note_sum = 8'(pitch_base(row_q)) + 8'(col_q) * 8'(SEMITONES);
  assign note     = (note_sum > 8'(NOTE_MAX)) ? NOTE_MAX : note_sum[6:0];

  // FSM next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_range) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (go_press) begin
          state_d = ST_DIV;
        end else if (go_release) begin
          state_d = ST_PUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_o || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  logic       res_load;
  logic       res_kind_d;
  logic [6:0] res_vel_d;
  logic       out_load;

  always_comb begin
    in_ready_o     = 1'b0;
    ks_ctrl        = '{rd_en: 1'b0, phase_we: 1'b0, time_we: 1'b0, phase: PH_IDLE};
    div_start      = 1'b0;
    res_load       = 1'b0;
    res_kind_d     = EV_NOTE_ON;
    res_vel_d      = 7'd0;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: ks_ctrl.rd_en = 1'b1;
      ST_EVAL: begin
        if (go_float) begin
          ks_ctrl.phase_we = 1'b1;
          ks_ctrl.time_we  = 1'b1;
          ks_ctrl.phase    = PH_FLOATING;
        end else if (go_press) begin
          ks_ctrl.phase_we = 1'b1;
          ks_ctrl.phase    = PH_PRESSED;
          div_start        = 1'b1;
        end else if (go_release) begin
          ks_ctrl.phase_we = 1'b1;
          ks_ctrl.phase    = PH_RELEASED;
          res_load         = 1'b1;
          res_kind_d       = EV_NOTE_OFF;
        end else if (go_rest) begin
          ks_ctrl.phase_we = 1'b1;
          ks_ctrl.phase    = PH_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          res_kind_d = EV_NOTE_ON;
          res_vel_d  = vel_calc;
        end
      end
      ST_PUSH: out_load = !out_valid_o || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pending result and output register
  logic       res_kind_q;
  logic [6:0] res_vel_q;
  logic       out_valid_q;
  logic       out_kind_q;
  logic [6:0] out_note_q;
  logic [6:0] out_vel_q;

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_kind_q <= res_kind_d;
      res_vel_q  <= res_vel_d;
    end
    if (out_load) begin
      out_kind_q <= res_kind_q;
      out_note_q <= note;
      out_vel_q  <= res_vel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_kind_q;
  assign note_number_o = out_note_q;
  assign velocity_o    = out_vel_q;

endmodule
